// File: hdl/dmc_pkg.sv
// Package for the direct-mapped cache tag lookup.
// Holds the geometry constants, the controller state type and the command struct.
// No dependencies.
`timescale 1ns / 1ps

package dmc_pkg;

	localparam int ADDR_BITS  = 32;
	localparam int NUM_LINES  = 128;
	localparam int LINE_BYTES = 32;
	localparam int OFF_BITS   = $clog2(LINE_BYTES);
	localparam int IDX_BITS   = $clog2(NUM_LINES);
	localparam int BLK_BITS   = ADDR_BITS - OFF_BITS;
	localparam int TAG_BITS   = BLK_BITS - IDX_BITS;
	localparam int CNT_BITS   = 32;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_LOOKUP
	} dmc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // capture the request and start the tag read
		logic resolve;  // compare, update the line and the counters
	} dmc_cmd_t;

endpackage

// File: hdl/direct_mapped_cache_tag_lookup.sv
// Direct-mapped cache tag lookup, top level.
// An accepted request resolves in LOOKUP, and done then strobes its registered result.
// No new request is taken in LOOKUP (busy) while the last one is resolved.
// Results are shown for one cycle and cannot be stalled by the receiver.
// Reset clears all valid bits and both counters at once; the tag RAM is not cleared.
// Depends on dmc_pkg, dmc_ctrl and dmc_datapath.
`timescale 1ns / 1ps

module direct_mapped_cache_tag_lookup
	import dmc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ADDR_BITS-1:0] address,
	output logic                 done,
	output logic [OFF_BITS-1:0]  byte_offset,
	output logic [BLK_BITS-1:0]  block_number,
	output logic [IDX_BITS-1:0]  line_index,
	output logic [TAG_BITS-1:0]  tag_value,
	output logic                 is_miss,
	output logic                 is_replacement,
	output logic [TAG_BITS-1:0]  evicted_tag,
	output logic [CNT_BITS-1:0]  hit_total,
	output logic [CNT_BITS-1:0]  miss_total
);

	dmc_cmd_t cmd;

	dmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	dmc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.address        (address),
		.byte_offset    (byte_offset),
		.block_number   (block_number),
		.line_index     (line_index),
		.tag_value      (tag_value),
		.is_miss        (is_miss),
		.is_replacement (is_replacement),
		.evicted_tag    (evicted_tag),
		.hit_total      (hit_total),
		.miss_total     (miss_total)
	);

endmodule

// File: hdl/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/dmc_ctrl.sv
// Controller state machine for the cache tag lookup.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_ctrl
	import dmc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output dmc_cmd_t  cmd
);

	dmc_state_t state_q, state_d;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.resolve;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.accept  = 1'b0;
		cmd.resolve = 1'b0;
		busy        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// The stored tag is on the RAM output in this cycle.
				busy        = 1'b1;
				cmd.resolve = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

// File: hdl/dmc_datapath.sv
// Datapath for the cache tag lookup: address split, valid bits, tag RAM, counters.
// Depends on dmc_pkg and dmc_ram.
`timescale 1ns / 1ps

module dmc_datapath
	import dmc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dmc_cmd_t            cmd,
	input  logic [ADDR_BITS-1:0] address,
	output logic [OFF_BITS-1:0] byte_offset,
	output logic [BLK_BITS-1:0] block_number,
	output logic [IDX_BITS-1:0] line_index,
	output logic [TAG_BITS-1:0] tag_value,
	output logic                is_miss,
	output logic                is_replacement,
	output logic [TAG_BITS-1:0] evicted_tag,
	output logic [CNT_BITS-1:0] hit_total,
	output logic [CNT_BITS-1:0] miss_total
);

	logic [ADDR_BITS-1:0] addr_q;
	logic [NUM_LINES-1:0] valid_q;
	logic [CNT_BITS-1:0]  hit_cnt_q;
	logic [CNT_BITS-1:0]  miss_cnt_q;
	logic                 miss_q;
	logic                 repl_q;
	logic [TAG_BITS-1:0]  evicted_q;

	logic [IDX_BITS-1:0]  idx;
	logic [TAG_BITS-1:0]  tag;
	logic [TAG_BITS-1:0]  stored_tag;
	logic                 line_valid;
	logic                 miss;
	logic                 repl;

	assign idx        = addr_q[OFF_BITS +: IDX_BITS];
	assign tag        = addr_q[ADDR_BITS-1 -: TAG_BITS];
	assign line_valid = valid_q[idx];
	assign miss       = !line_valid || (stored_tag != tag);
	assign repl       = line_valid && (stored_tag != tag);

	dmc_ram #(
		.WIDTH (TAG_BITS),
		.DEPTH (NUM_LINES)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (cmd.resolve && miss),
		.wr_addr (idx),
		.wr_data (tag),
		.rd_en   (cmd.accept),
		.rd_addr (address[OFF_BITS +: IDX_BITS]),
		.rd_data (stored_tag)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= address;
		end
		if (cmd.resolve) begin
			miss_q    <= miss;
			repl_q    <= repl;
			evicted_q <= repl ? stored_tag : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (cmd.resolve) begin
			valid_q[idx] <= 1'b1;
			// Both counters stick at all ones.
			if (miss) begin
				if (miss_cnt_q != '1) begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end else if (hit_cnt_q != '1) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
		end
	end

	assign byte_offset    = addr_q[OFF_BITS-1:0];
	assign block_number   = addr_q[ADDR_BITS-1:OFF_BITS];
	assign line_index     = idx;
	assign tag_value      = tag;
	assign is_miss        = miss_q;
	assign is_replacement = repl_q;
	assign evicted_tag    = evicted_q;
	assign hit_total      = hit_cnt_q;
	assign miss_total     = miss_cnt_q;

endmodule

// File: hdl/dmc_checker.sv
// Port-level checks for the cache tag lookup, bound to the top level.
// Depends on dmc_pkg and direct_mapped_cache_tag_lookup.
`timescale 1ns / 1ps

module dmc_checker
	import dmc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [BLK_BITS-1:0] block_number,
	input logic [IDX_BITS-1:0] line_index,
	input logic [TAG_BITS-1:0] tag_value,
	input logic                is_miss,
	input logic                is_replacement,
	input logic [TAG_BITS-1:0] evicted_tag
);

	// Every accepted request yields a result strobed on done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted request produced no result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a request");

	a_repl_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_replacement) |-> is_miss)
		else $error("replacement reported on a hit");

	a_evicted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_replacement) |-> (evicted_tag == '0))
		else $error("evicted tag nonzero without replacement");

	a_block_split: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (block_number == {tag_value, line_index}))
		else $error("block number does not match tag and index");

endmodule

bind direct_mapped_cache_tag_lookup dmc_checker u_dmc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.block_number   (block_number),
	.line_index     (line_index),
	.tag_value      (tag_value),
	.is_miss        (is_miss),
	.is_replacement (is_replacement),
	.evicted_tag    (evicted_tag)
);

// File: dv/direct_mapped_cache_tag_lookup_checker.sv
// Checker for the direct-mapped cache tag lookup: watches requests and results,
// keeps its own copy of the valid bits, tags and counters, and compares each result.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module direct_mapped_cache_tag_lookup_checker
	import dmc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [ADDR_BITS-1:0] address,
	input  logic                 done,
	input  logic [OFF_BITS-1:0]  byte_offset,
	input  logic [BLK_BITS-1:0]  block_number,
	input  logic [IDX_BITS-1:0]  line_index,
	input  logic [TAG_BITS-1:0]  tag_value,
	input  logic                 is_miss,
	input  logic                 is_replacement,
	input  logic [TAG_BITS-1:0]  evicted_tag,
	input  logic [CNT_BITS-1:0]  hit_total,
	input  logic [CNT_BITS-1:0]  miss_total,
	output int                   error_count,
	output int                   pending_count,
	output int                   hits_seen,
	output int                   misses_seen,
	output int                   evictions_seen
);

	typedef struct packed {
		logic [OFF_BITS-1:0] byte_offset;
		logic [BLK_BITS-1:0] block_number;
		logic [IDX_BITS-1:0] line_index;
		logic [TAG_BITS-1:0] tag_value;
		logic                is_miss;
		logic                is_replacement;
		logic [TAG_BITS-1:0] evicted_tag;
		logic [CNT_BITS-1:0] hit_total;
		logic [CNT_BITS-1:0] miss_total;
	} lookup_result_t;

	logic                line_valid_copy [NUM_LINES];
	logic [TAG_BITS-1:0] line_tag_copy [NUM_LINES];
	logic [CNT_BITS-1:0] hit_count;
	logic [CNT_BITS-1:0] miss_count;

	lookup_result_t expected_lookups [$];
	lookup_result_t oldest;
	lookup_result_t predicted;
	logic [IDX_BITS-1:0] req_index;
	logic [TAG_BITS-1:0] req_tag;

	initial begin
		for (int i = 0; i < NUM_LINES; i++) begin
			line_valid_copy[i] = 1'b0;
			line_tag_copy[i] = '0;
		end
		hit_count = '0;
		miss_count = '0;
		error_count = 0;
		pending_count = 0;
		hits_seen = 0;
		misses_seen = 0;
		evictions_seen = 0;
	end

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
					$realtime, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// Results are registered, so the one shown now belongs to an earlier request.
			if (done === 1'b1) begin
				if (expected_lookups.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: result strobed with no request outstanding", $realtime);
				end else begin
					oldest = expected_lookups.pop_front();
					check_field("byte_offset", 32'(oldest.byte_offset), 32'(byte_offset));
					check_field("block_number", 32'(oldest.block_number),
						32'(block_number));
					check_field("line_index", 32'(oldest.line_index), 32'(line_index));
					check_field("tag_value", 32'(oldest.tag_value), 32'(tag_value));
					check_field("is_miss", 32'(oldest.is_miss), 32'(is_miss));
					check_field("is_replacement", 32'(oldest.is_replacement),
						32'(is_replacement));
					check_field("evicted_tag", 32'(oldest.evicted_tag), 32'(evicted_tag));
					check_field("hit_total", oldest.hit_total, hit_total);
					check_field("miss_total", oldest.miss_total, miss_total);
				end
			end

			if (start === 1'b1 && busy === 1'b0) begin
				req_index = address[OFF_BITS +: IDX_BITS];
				req_tag = address[ADDR_BITS-1 -: TAG_BITS];
				predicted.byte_offset = address[OFF_BITS-1:0];
				predicted.block_number = address[ADDR_BITS-1:OFF_BITS];
				predicted.line_index = req_index;
				predicted.tag_value = req_tag;
				predicted.is_miss = 1'b0;
				predicted.is_replacement = 1'b0;
				predicted.evicted_tag = '0;
				if (!line_valid_copy[req_index]) begin
					line_valid_copy[req_index] = 1'b1;
					line_tag_copy[req_index] = req_tag;
					predicted.is_miss = 1'b1;
				end else if (line_tag_copy[req_index] != req_tag) begin
					predicted.evicted_tag = line_tag_copy[req_index];
					line_tag_copy[req_index] = req_tag;
					predicted.is_miss = 1'b1;
					predicted.is_replacement = 1'b1;
					evictions_seen++;
				end
				// Both counters stop at all ones.
				if (predicted.is_miss) begin
					if (miss_count != '1)
						miss_count = miss_count + 1'b1;
					misses_seen++;
				end else begin
					if (hit_count != '1)
						hit_count = hit_count + 1'b1;
					hits_seen++;
				end
				predicted.hit_total = hit_count;
				predicted.miss_total = miss_count;
				expected_lookups.push_back(predicted);
			end
			pending_count <= expected_lookups.size();
		end
	end

endmodule

// File: dv/direct_mapped_cache_tag_lookup_tb.sv
// Testbench top for the direct-mapped cache tag lookup: clock, reset, request stimulus
// and the verdict. Depends on dmc_pkg, the block and direct_mapped_cache_tag_lookup_checker.
`timescale 1ns / 1ps

module direct_mapped_cache_tag_lookup_tb;
	import dmc_pkg::*;

	localparam int NUM_DIRECTED = 14;
	localparam int NUM_RANDOM = 450;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [ADDR_BITS-1:0] address = '0;
	logic                 done;
	logic [OFF_BITS-1:0]  byte_offset;
	logic [BLK_BITS-1:0]  block_number;
	logic [IDX_BITS-1:0]  line_index;
	logic [TAG_BITS-1:0]  tag_value;
	logic                 is_miss;
	logic                 is_replacement;
	logic [TAG_BITS-1:0]  evicted_tag;
	logic [CNT_BITS-1:0]  hit_total;
	logic [CNT_BITS-1:0]  miss_total;

	int error_count;
	int pending_count;
	int hits_seen;
	int misses_seen;
	int evictions_seen;

	direct_mapped_cache_tag_lookup u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.address       (address),
		.done          (done),
		.byte_offset   (byte_offset),
		.block_number  (block_number),
		.line_index    (line_index),
		.tag_value     (tag_value),
		.is_miss       (is_miss),
		.is_replacement(is_replacement),
		.evicted_tag   (evicted_tag),
		.hit_total     (hit_total),
		.miss_total    (miss_total)
	);

	direct_mapped_cache_tag_lookup_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.address       (address),
		.done          (done),
		.byte_offset   (byte_offset),
		.block_number  (block_number),
		.line_index    (line_index),
		.tag_value     (tag_value),
		.is_miss       (is_miss),
		.is_replacement(is_replacement),
		.evicted_tag   (evicted_tag),
		.hit_total     (hit_total),
		.miss_total    (miss_total),
		.error_count   (error_count),
		.pending_count (pending_count),
		.hits_seen     (hits_seen),
		.misses_seen   (misses_seen),
		.evictions_seen(evictions_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Timed out with %0d results outstanding", pending_count);
		$display("TEST FAILED");
		$finish;
	end

	logic [ADDR_BITS-1:0] directed_addrs [NUM_DIRECTED];
	logic [TAG_BITS-1:0]  tag_pool [4];
	logic [ADDR_BITS-1:0] next_addr;
	logic [ADDR_BITS-1:0] last_addr;
	logic [IDX_BITS-1:0]  pick_index;
	logic [OFF_BITS-1:0]  pick_offset;
	logic [TAG_BITS-1:0]  pick_tag;
	int                   choice;
	bit                   quiet_stretch;

	initial begin
		// Cold fills, hits at both offset extremes, evictions of the all-zero and
		// all-one tags in both directions, and alternating bit patterns.
		directed_addrs = '{
			32'h0000_0000, 32'h0000_001F, 32'hFFFF_FFFF, 32'hFFFF_FFE0,
			32'hFFFF_F000, 32'h0000_0000, 32'h0000_0FFF, 32'h0000_0FE0,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AABF, 32'h8000_0000,
			32'h0000_0020, 32'h7FFF_F03C
		};
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		tag_pool[2] = TAG_BITS'($urandom());
		tag_pool[3] = TAG_BITS'($urandom());
		last_addr = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < NUM_DIRECTED + NUM_RANDOM; n++) begin
			if (n < NUM_DIRECTED) begin
				next_addr = directed_addrs[n];
			end else begin
				// Mostly a few tags over a few lines, so that hits and evictions are common.
				choice = $urandom_range(99);
				pick_offset = OFF_BITS'($urandom());
				pick_index = IDX_BITS'(($urandom_range(99) < 70) ? $urandom_range(15)
					: $urandom_range(127));
				pick_tag = tag_pool[2'($urandom_range(3))];
				if (choice < 15)
					next_addr = $urandom();
				else if (choice < 40)
					next_addr = {last_addr[ADDR_BITS-1:OFF_BITS], pick_offset};
				else
					next_addr = {pick_tag, pick_index, pick_offset};
				if ($urandom_range(99) < 3)
					tag_pool[2'($urandom_range(2, 3))] = TAG_BITS'($urandom());
			end
			last_addr = next_addr;

			quiet_stretch = (n >= 150 && n < 300);
			if (!quiet_stretch && $urandom_range(99) < 14) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			start <= 1'b1;
			address <= next_addr;
			do @(posedge clk); while (busy !== 1'b0);
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d requests (%0d directed): %0d hits, %0d misses, %0d evictions.",
			NUM_DIRECTED + NUM_RANDOM, NUM_DIRECTED, hits_seen, misses_seen, evictions_seen);
		$display("Mismatches and unexpected results: %0d", error_count);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/dmc_pkg.sv
hdl/dmc_ram.sv
hdl/dmc_ctrl.sv
hdl/dmc_datapath.sv
hdl/direct_mapped_cache_tag_lookup.sv
hdl/dmc_checker.sv
dv/direct_mapped_cache_tag_lookup_checker.sv
dv/direct_mapped_cache_tag_lookup_tb.sv
